### sv/epad_pkg.sv
`default_nettype none

package epad_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIR_X = 2'd0,
    REG_DIR_Y = 2'd1,
    REG_DIR_Z = 2'd2
  } epad_reg_e;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } epad_ctl_t;

endpackage

`default_nettype wire

### sv/epad_key.sv
`default_nettype none

module epad_key #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,
  input  wire logic                         accept_i,
  input  wire logic signed [COORD_BITS-1:0] pt_i [3],
  input  wire logic                         last_i,
  input  wire logic signed [COORD_BITS-1:0] dir_i [3],
  output epad_pkg::epad_ctl_t               ctl_o,
  output logic signed [2*COORD_BITS+2:0]    key_o,
  output logic signed [COORD_BITS-1:0]      pt_o [3]
);
  import epad_pkg::*;

  localparam int unsigned N   = COORD_BITS;
  localparam int unsigned DW  = N + 1;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned PW  = DW + N;
  localparam int unsigned KW  = 2 * N + 3;

  logic                have_base_q;
  logic signed [N-1:0] base_q [3];

  epad_ctl_t           ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic signed [N-1:0] p1_q [3];
  logic signed [N-1:0] p2_q [3];
  logic signed [N-1:0] p3_q [3];
  logic signed [N-1:0] p4_q [3];

  logic signed [DW-1:0]  d2_d [3];
  logic signed [DW-1:0]  d2_q [3];
  logic signed [SQW-1:0] sq3_d [3];
  logic signed [SQW-1:0] sq3_q [3];
  logic signed [PW-1:0]  dt3_d [3];
  logic signed [PW-1:0]  dt3_q [3];
  logic signed [KW-1:0]  sq_sum;
  logic signed [KW-1:0]  dot_sum;
  logic signed [KW-1:0]  key4_d;
  logic signed [KW-1:0]  key4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_base_q <= 1'b0;
    end else if (accept_i) begin
      have_base_q <= !last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !have_base_q) begin
      base_q <= pt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else if (adv_i) begin
      ctl1_q.valid <= accept_i;
      ctl1_q.first <= !have_base_q;
      ctl1_q.last  <= last_i;
      ctl2_q       <= ctl1_q;
      ctl3_q       <= ctl2_q;
      ctl4_q       <= ctl3_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d2_d[i]  = $signed({p1_q[i][N-1], p1_q[i]}) - $signed({base_q[i][N-1], base_q[i]});
      sq3_d[i] = SQW'(d2_q[i]) * SQW'(d2_q[i]);
      dt3_d[i] = PW'(d2_q[i]) * PW'(dir_i[i]);
    end
  end

  always_comb begin
    sq_sum  = '0;
    dot_sum = '0;
    for (int i = 0; i < 3; i++) begin
      sq_sum  = sq_sum + $signed({{(KW-SQW){sq3_q[i][SQW-1]}}, sq3_q[i]});
      dot_sum = dot_sum + $signed({{(KW-PW){dt3_q[i][PW-1]}}, dt3_q[i]});
    end
    key4_d = (!dot_sum[KW-1] && (dot_sum != '0)) ? sq_sum : -sq_sum;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p1_q   <= pt_i;
      p2_q   <= p1_q;
      d2_q   <= d2_d;
      p3_q   <= p2_q;
      sq3_q  <= sq3_d;
      dt3_q  <= dt3_d;
      p4_q   <= p3_q;
      key4_q <= key4_d;
    end
  end

  assign ctl_o = ctl4_q;
  assign key_o = key4_q;
  assign pt_o  = p4_q;

endmodule

`default_nettype wire

### sv/epad_track.sv
`default_nettype none

module epad_track #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire epad_pkg::epad_ctl_t          ctl_i,
  input  wire logic signed [2*COORD_BITS+2:0] key_i,
  input  wire logic signed [COORD_BITS-1:0] pt_i [3],
  input  wire logic                         out_stall_i,
  output logic                              adv_o,
  output logic                              out_valid_o,
  output logic signed [COORD_BITS-1:0]      min_pt_o [3],
  output logic signed [COORD_BITS-1:0]      max_pt_o [3]
);
  import epad_pkg::*;

  localparam int unsigned N  = COORD_BITS;
  localparam int unsigned KW = 2 * N + 3;

  logic signed [KW-1:0] min_key_d, min_key_q;
  logic signed [KW-1:0] max_key_d, max_key_q;
  logic signed [N-1:0]  min_pt_d [3];
  logic signed [N-1:0]  min_pt_q [3];
  logic signed [N-1:0]  max_pt_d [3];
  logic signed [N-1:0]  max_pt_q [3];
  logic signed [N-1:0]  out_min_q [3];
  logic signed [N-1:0]  out_max_q [3];
  logic                 out_valid_q;
  logic                 fire;

  assign adv_o = !(out_valid_q && out_stall_i && ctl_i.valid && ctl_i.last);
  assign fire  = adv_o && ctl_i.valid;

  always_comb begin
    min_key_d = min_key_q;
    max_key_d = max_key_q;
    min_pt_d  = min_pt_q;
    max_pt_d  = max_pt_q;
    if (ctl_i.first) begin
      min_key_d = '0;
      max_key_d = '0;
      min_pt_d  = pt_i;
      max_pt_d  = pt_i;
    end else begin
      if (key_i < min_key_q) begin
        min_key_d = key_i;
        min_pt_d  = pt_i;
      end
      if (key_i > max_key_q) begin
        max_key_d = key_i;
        max_pt_d  = pt_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      min_key_q <= min_key_d;
      max_key_q <= max_key_d;
      min_pt_q  <= min_pt_d;
      max_pt_q  <= max_pt_d;
      if (ctl_i.last) begin
        out_min_q <= min_pt_d;
        out_max_q <= max_pt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && ctl_i.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_pt_o    = out_min_q;
  assign max_pt_o    = out_max_q;

endmodule

`default_nettype wire

### sv/extreme_points_along_direction.sv
`default_nettype none

// Finds the two extreme points of a point set along a configured direction.
// The first point of a set is the base; every later point is ranked by its
// squared distance from the base, negated when it does not lie ahead of the
// base along the direction. The word marked last closes the set and produces
// one result word carrying the lowest-ranked and highest-ranked points; ties
// keep the earlier point. The block takes one point per clock cycle while the
// input is not stalled; the last point of a set passes through the ranking
// pipeline (subtract, multiply, sum, compare), whose compare stage loads the
// output register. The input is stalled only while a finished result is
// still held and the next closing point has reached the compare stage. The
// direction registers may be written only while the block is idle.

module extreme_points_along_direction #(
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [epad_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [COORD_BITS-1:0]            cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]     pt_x_i,
  input  wire logic signed [COORD_BITS-1:0]     pt_y_i,
  input  wire logic signed [COORD_BITS-1:0]     pt_z_i,
  input  wire logic                             last_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [COORD_BITS-1:0]          min_x_o,
  output logic signed [COORD_BITS-1:0]          min_y_o,
  output logic signed [COORD_BITS-1:0]          min_z_o,
  output logic signed [COORD_BITS-1:0]          max_x_o,
  output logic signed [COORD_BITS-1:0]          max_y_o,
  output logic signed [COORD_BITS-1:0]          max_z_o
);
  import epad_pkg::*;

  localparam int unsigned N  = COORD_BITS;
  localparam int unsigned KW = 2 * N + 3;

  logic signed [N-1:0]  dir_q [3];
  logic signed [N-1:0]  pt [3];
  logic signed [N-1:0]  key_pt [3];
  logic signed [N-1:0]  min_pt [3];
  logic signed [N-1:0]  max_pt [3];
  logic signed [KW-1:0] key;
  epad_ctl_t            key_ctl;
  logic                 adv;
  logic                 accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q[0] <= '0;
      dir_q[1] <= '0;
      dir_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DIR_X: dir_q[0] <= cfg_data_i;
        REG_DIR_Y: dir_q[1] <= cfg_data_i;
        REG_DIR_Z: dir_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pt[0]      = pt_x_i;
  assign pt[1]      = pt_y_i;
  assign pt[2]      = pt_z_i;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  epad_key #(
    .COORD_BITS(COORD_BITS)
  ) u_key (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .accept_i (accept),
    .pt_i     (pt),
    .last_i   (last_i),
    .dir_i    (dir_q),
    .ctl_o    (key_ctl),
    .key_o    (key),
    .pt_o     (key_pt)
  );

  epad_track #(
    .COORD_BITS(COORD_BITS)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (key_ctl),
    .key_i       (key),
    .pt_i        (key_pt),
    .out_stall_i (out_stall_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .min_pt_o    (min_pt),
    .max_pt_o    (max_pt)
  );

  assign min_x_o = min_pt[0];
  assign min_y_o = min_pt[1];
  assign min_z_o = min_pt[2];
  assign max_x_o = max_pt[0];
  assign max_y_o = max_pt[1];
  assign max_z_o = max_pt[2];

endmodule

`default_nettype wire

### tb/extreme_points_along_direction_test.sv
`timescale 1ns / 1ps

module extreme_points_along_direction_test;
  import epad_pkg::*;

  localparam int unsigned COORD_BITS = 24;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LONG_HOLD_CYCLES = 300;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;
  localparam coord_t UNIT = 24'sd4096;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int unsigned {
    SPREAD_FULL,
    SPREAD_NEAR,
    SPREAD_EDGE
  } spread_e;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } extremes_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [COORD_BITS-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  coord_t pt_x_i;
  coord_t pt_y_i;
  coord_t pt_z_i;
  logic last_i;
  logic out_valid_o;
  logic out_stall_i;
  coord_t min_x_o;
  coord_t min_y_o;
  coord_t min_z_o;
  coord_t max_x_o;
  coord_t max_y_o;
  coord_t max_z_o;

  coord_t dir_q [3];
  bit have_base;
  coord_t base_pt [3];
  coord_t min_pt [3];
  coord_t max_pt [3];
  longint min_key;
  longint max_key;
  extremes_t pending_extremes [$];
  extremes_t exp_w;

  bit idle_en;
  bit long_hold_req;
  int unsigned mismatches;
  int unsigned points_sent;
  int unsigned sets_closed;
  int unsigned results_checked;
  int unsigned dir_settings;

  extreme_points_along_direction #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pt_x_i     (pt_x_i),
    .pt_y_i     (pt_y_i),
    .pt_z_i     (pt_z_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .min_x_o    (min_x_o),
    .min_y_o    (min_y_o),
    .min_z_o    (min_z_o),
    .max_x_o    (max_x_o),
    .max_y_o    (max_y_o),
    .max_z_o    (max_z_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void track_extremes(input coord_t x, input coord_t y, input coord_t z,
                                         input logic lst);
    coord_t p [3];
    longint sq;
    longint dot;
    longint d;
    longint key;
    extremes_t res;
    p = '{x, y, z};
    if (!have_base) begin
      have_base = 1'b1;
      base_pt = p;
      min_pt = p;
      max_pt = p;
      min_key = 0;
      max_key = 0;
    end else begin
      sq = 0;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        d = longint'(p[i]) - longint'(base_pt[i]);
        sq += d * d;
        dot += d * longint'(dir_q[i]);
      end
      key = (dot > 0) ? sq : -sq;
      if (key < min_key) begin
        min_key = key;
        min_pt = p;
      end
      if (key > max_key) begin
        max_key = key;
        max_pt = p;
      end
    end
    if (lst) begin
      res.min_x = min_pt[0];
      res.min_y = min_pt[1];
      res.min_z = min_pt[2];
      res.max_x = max_pt[0];
      res.max_y = max_pt[1];
      res.max_z = max_pt[2];
      pending_extremes.push_back(res);
      have_base = 1'b0;
      sets_closed++;
    end
  endfunction

  function automatic void check_field(input string name, input coord_t exp_v,
                                      input coord_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  function automatic coord_t rand_coord(input spread_e sp);
    case (sp)
      SPREAD_NEAR: return coord_t'($urandom_range(0, 16) - 8);
      SPREAD_EDGE: begin
        case ($urandom_range(0, 3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic spread_e rand_spread();
    return spread_e'($urandom_range(0, 2));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_extremes.size() == 0) begin
        $error("result word arrived with no expected result pending");
        mismatches++;
      end else begin
        exp_w = pending_extremes.pop_front();
        check_field("min_x", exp_w.min_x, min_x_o);
        check_field("min_y", exp_w.min_y, min_y_o);
        check_field("min_z", exp_w.min_z, min_z_o);
        check_field("max_x", exp_w.max_x, max_x_o);
        check_field("max_y", exp_w.max_y, max_y_o);
        check_field("max_z", exp_w.max_z, max_z_o);
        results_checked++;
      end
    end
  end

  always begin
    @(posedge clk_i);
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      out_stall_i <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  task automatic set_direction(input coord_t dx, input coord_t dy, input coord_t dz);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_DIR_X;
    cfg_data_i <= dx;
    @(posedge clk_i);
    cfg_idx_i <= REG_DIR_Y;
    cfg_data_i <= dy;
    @(posedge clk_i);
    cfg_idx_i <= REG_DIR_Z;
    cfg_data_i <= dz;
    @(posedge clk_i);
    // The spare index must leave all three direction registers alone.
    cfg_idx_i <= REG_UNUSED;
    cfg_data_i <= COORD_BITS'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dir_q = '{dx, dy, dz};
    dir_settings++;
  endtask

  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input logic lst);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pt_x_i <= x;
    pt_y_i <= y;
    pt_z_i <= z;
    last_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_extremes(x, y, z, lst);
    points_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_extremes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_sets(input int unsigned total);
    int unsigned n;
    int unsigned sent;
    spread_e sp;
    sent = 0;
    while (sent < total) begin
      n = $urandom_range(1, 12);
      sp = rand_spread();
      for (int k = 0; k < n; k++) begin
        send_point(rand_coord(sp), rand_coord(sp), rand_coord(sp), k == n - 1);
      end
      sent += n;
    end
  endtask

  task automatic test_single_point_sets();
    set_direction(UNIT, '0, '0);
    send_point(COORD_MAX, COORD_MIN, '0, 1'b1);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
    drain();
  endtask

  task automatic test_ties_and_zero_dot();
    // Equal distances on each side: the earlier point has to win both ties,
    // and a point square to the direction counts as behind it.
    send_point('0, '0, '0, 1'b0);
    send_point(24'sd300, 24'sd400, '0, 1'b0);
    send_point(24'sd400, 24'sd300, '0, 1'b0);
    send_point(-24'sd300, '0, 24'sd400, 1'b0);
    send_point('0, -24'sd500, '0, 1'b0);
    send_point('0, '0, '0, 1'b1);
    drain();
  endtask

  task automatic test_full_range();
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    drain();
  endtask

  task automatic test_zero_direction();
    set_direction('0, '0, '0);
    send_point(24'sd5, 24'sd5, 24'sd5, 1'b0);
    send_point(24'sd1000, -24'sd1000, '0, 1'b0);
    send_point(24'sd7, 24'sd7, 24'sd7, 1'b1);
    drain();
  endtask

  task automatic test_extreme_direction();
    set_direction(COORD_MIN, COORD_MAX, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0);
    send_point('0, '0, '0, 1'b1);
    drain();
    set_direction(COORD_MAX, COORD_MIN, COORD_MAX);
    send_point('0, '0, '0, 1'b0);
    send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
    drain();
  endtask

  task automatic test_random_sets();
    for (int ph = 0; ph < 6; ph++) begin
      set_direction(rand_coord(rand_spread()), rand_coord(rand_spread()),
                    rand_coord(rand_spread()));
      send_random_sets(100);
      drain();
    end
  endtask

  task automatic test_output_hold();
    set_direction(rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL));
    long_hold_req = 1'b1;
    for (int k = 0; k < 60; k++) begin
      send_point(rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL),
                 (k % 2) == 1);
    end
    drain();
  endtask

  task automatic test_full_rate();
    idle_en = 1'b0;
    set_direction(rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL), rand_coord(SPREAD_FULL));
    send_random_sets(60);
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_DIR_X;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    pt_x_i = '0;
    pt_y_i = '0;
    pt_z_i = '0;
    last_i = 1'b0;
    out_stall_i = 1'b0;
    dir_q = '{'0, '0, '0};
    have_base = 1'b0;
    idle_en = 1'b1;
    long_hold_req = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_point_sets();
    test_ties_and_zero_dot();
    test_full_range();
    test_zero_direction();
    test_extreme_direction();
    test_random_sets();
    test_output_hold();
    test_full_rate();

    $display("Sent %0d points in %0d sets under %0d direction settings, with a long output hold.",
             points_sent, sets_closed, dir_settings);
    $display("Compared %0d result words; %0d field mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
